>>> src/hrked_pkg.sv
// Package for the HID report key event diff block.
// Holds report ids, usage pages, modifier usage base and the sequencer load struct.
// No dependencies.
package hrked_pkg;

    // report ids
    localparam logic [7:0] REPORT_KEYBOARD = 8'd1;
    localparam logic [7:0] REPORT_CONSUMER = 8'd2;

    // minimum report length for keyboard and consumer reports
    localparam logic [7:0] MIN_REPORT_LEN = 8'd3;

    // usage pages
    localparam logic [7:0] PAGE_KEYBOARD = 8'h07;
    localparam logic [7:0] PAGE_CONSUMER = 8'h0C;

    // first modifier usage (left control), one per modifier bit
    localparam logic [15:0] MOD_USAGE_FIRST = 16'd224;
    localparam int MOD_BITS = 8;

    // key slots that a boot keyboard report can carry
    localparam int MAX_SLOTS = 6;

    // key code and usage widths
    localparam int KEY_W   = 8;
    localparam int USAGE_W = 16;
    localparam int COUNT_W = 3;

    // load request from the diff stage to the event sequencer
    typedef struct packed {
        logic       load;
        logic [7:0] page;
    } seq_load_t;

endpackage

>>> src/hid_report_key_event_diff.sv
// HID report to key event converter, top level.
// Each accepted report is latched into the event sequencer's pending mask, and each event word
// then passes through its output register; one event word per cycle while m_tready is high.
// A report holds the input until all its events have left the pending mask, set by the one-word event sequencer.
// Reset: clears held keys, count, modifiers and consumer usage, and empties the output.
// Depends on hrked_pkg, hrked_lane and hrked_seq.
module hid_report_key_event_diff #(
    parameter int KEY_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // report_length, byte_one, byte_two, key_slot_0..key_slot_5
    input  logic [7:0]  s_tuser,  // rpt_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // usage_page[7:0], usage_code[23:8], pressed[24]
    output logic        m_tlast   // last_event
);

    localparam int USED = (KEY_SLOTS < hrked_pkg::MAX_SLOTS) ? KEY_SLOTS : hrked_pkg::MAX_SLOTS;
    localparam int NC   = 2 * USED + hrked_pkg::MOD_BITS;
    localparam int KW   = hrked_pkg::KEY_W;
    localparam int UW   = hrked_pkg::USAGE_W;
    localparam int CW   = hrked_pkg::COUNT_W;

    logic [7:0]  rpt_id, report_length, byte_one, byte_two;
    logic [UW-1:0] usage;
    logic [USED-1:0][KW-1:0] new_keys;

    logic [USED-1:0][KW-1:0] held_keys_reg, held_keys_next;
    logic [CW-1:0]           held_count_reg, held_count_next;
    logic [7:0]              held_mod_reg, held_mod_next;
    logic [UW-1:0]           held_cons_reg, held_cons_next;

    logic [7:0]    len_m3;
    logic [CW-1:0] slot_cnt;
    logic [USED-1:0] new_mask, held_mask, press_hit, rel_hit;
    logic is_kb, is_cons, accept, seq_idle;

    logic [NC-1:0]           cand_valid, cand_press;
    logic [NC-1:0][UW-1:0]   cand_code;
    hrked_pkg::seq_load_t    ld;

    // unpack the input word
    assign rpt_id        = s_tuser;
    assign report_length = s_tdata[7:0];
    assign byte_one      = s_tdata[15:8];
    assign byte_two      = s_tdata[23:16];
    assign usage         = {byte_two, byte_one};

    for (genvar g = 0; g < USED; g++) begin : g_keys
        assign new_keys[g] = s_tdata[24 + KW * g +: KW];
    end

    assign is_kb   = (rpt_id == hrked_pkg::REPORT_KEYBOARD) &&
                     (report_length >= hrked_pkg::MIN_REPORT_LEN);
    assign is_cons = (rpt_id == hrked_pkg::REPORT_CONSUMER) &&
                     (report_length >= hrked_pkg::MIN_REPORT_LEN);

    assign s_tready = seq_idle;
    assign accept   = s_tvalid && s_tready;

    // used slot count: min(length - 3, slots)
    assign len_m3   = report_length - hrked_pkg::MIN_REPORT_LEN;
    assign slot_cnt = (len_m3 >= 8'(USED)) ? CW'(USED) : len_m3[CW-1:0];

    always_comb begin
        for (int i = 0; i < USED; i++) begin
            new_mask[i]  = CW'(i) < slot_cnt;
            held_mask[i] = CW'(i) < held_count_reg;
        end
    end

    // one lane per new key and one per held key
    for (genvar g = 0; g < USED; g++) begin : g_lane
        hrked_lane #(.N(USED)) u_press (
            .key  (new_keys[g]),
            .list (held_keys_reg),
            .mask (held_mask),
            .hit  (press_hit[g])
        );
        hrked_lane #(.N(USED)) u_release (
            .key  (held_keys_reg[g]),
            .list (new_keys),
            .mask (new_mask),
            .hit  (rel_hit[g])
        );
    end

    // merge lane results into the ordered candidate list
    always_comb begin
        cand_valid = '0;
        cand_code  = '0;
        cand_press = '0;
        ld.load    = accept;
        ld.page    = hrked_pkg::PAGE_KEYBOARD;
        if (is_kb) begin
            for (int i = 0; i < USED; i++) begin
                cand_valid[i] = new_mask[i] && (new_keys[i] != '0) && !press_hit[i];
                cand_code[i]  = UW'(new_keys[i]);
                cand_press[i] = 1'b1;
                cand_valid[USED + i] = held_mask[i] && (held_keys_reg[i] != '0) && !rel_hit[i];
                cand_code[USED + i]  = UW'(held_keys_reg[i]);
                cand_press[USED + i] = 1'b0;
            end
            for (int b = 0; b < hrked_pkg::MOD_BITS; b++) begin
                cand_valid[2 * USED + b] = byte_one[b] ^ held_mod_reg[b];
                cand_code[2 * USED + b]  = hrked_pkg::MOD_USAGE_FIRST + UW'(b);
                cand_press[2 * USED + b] = byte_one[b];
            end
        end else if (is_cons) begin
            ld.page       = hrked_pkg::PAGE_CONSUMER;
            cand_valid[0] = (usage != held_cons_reg) && (held_cons_reg != '0);
            cand_code[0]  = held_cons_reg;
            cand_press[0] = 1'b0;
            cand_valid[1] = (usage != held_cons_reg) && (usage != '0);
            cand_code[1]  = usage;
            cand_press[1] = 1'b1;
        end
    end

    // store the report as the new held state
    always_comb begin
        held_keys_next  = held_keys_reg;
        held_count_next = held_count_reg;
        held_mod_next   = held_mod_reg;
        held_cons_next  = held_cons_reg;
        if (accept && is_kb) begin
            for (int i = 0; i < USED; i++) begin
                held_keys_next[i] = new_mask[i] ? new_keys[i] : '0;
            end
            held_count_next = slot_cnt;
            held_mod_next   = byte_one;
        end
        if (accept && is_cons) begin
            held_cons_next = usage;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_keys_reg  <= '0;
            held_count_reg <= '0;
            held_mod_reg   <= '0;
            held_cons_reg  <= '0;
        end else begin
            held_keys_reg  <= held_keys_next;
            held_count_reg <= held_count_next;
            held_mod_reg   <= held_mod_next;
            held_cons_reg  <= held_cons_next;
        end
    end

    // send the events one word at a time
    hrked_seq #(.NC(NC)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ld         (ld),
        .cand_valid (cand_valid),
        .cand_code  (cand_code),
        .cand_press (cand_press),
        .idle       (seq_idle),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> src/hrked_lane.sv
// One compare lane: looks for a key code in a masked list of key codes.
// Depends on hrked_pkg for the key width.
module hrked_lane #(
    parameter int N = 6
) (
    input  logic [hrked_pkg::KEY_W-1:0]        key,
    input  logic [N-1:0][hrked_pkg::KEY_W-1:0] list,
    input  logic [N-1:0]                       mask,
    output logic                               hit
);

    logic [N-1:0] match;

    // compare against every enabled entry
    always_comb begin
        for (int i = 0; i < N; i++) begin
            match[i] = mask[i] && (list[i] == key);
        end
    end

    assign hit = |match;

endmodule

>>> src/hrked_seq.sv
// Event sequencer: holds the candidate events of one report and sends the
// set ones in order, one word per cycle while m_tready is high, through an output register.
// Depends on hrked_pkg for the load struct and widths.
module hrked_seq #(
    parameter int NC = 20
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hrked_pkg::seq_load_t                  ld,
    input  logic [NC-1:0]                         cand_valid,
    input  logic [NC-1:0][hrked_pkg::USAGE_W-1:0] cand_code,
    input  logic [NC-1:0]                         cand_press,
    output logic                                  idle,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata,  // page[7:0], code[23:8], pressed[24]
    output logic                                  m_tlast
);

    localparam int SW = (NC > 1) ? $clog2(NC) : 1;

    logic [NC-1:0]                         pend_reg, pend_next;
    logic [NC-1:0][hrked_pkg::USAGE_W-1:0] code_reg;
    logic [NC-1:0]                         press_reg;
    logic [7:0]                            page_reg;
    logic                                  m_valid_reg, m_valid_next;
    logic [7:0]                            m_page_reg;
    logic [hrked_pkg::USAGE_W-1:0]         m_code_reg;
    logic                                  m_press_reg;
    logic                                  m_last_reg;

    logic [SW-1:0] sel;
    logic [NC-1:0] rest;
    logic          any;
    logic          emit;
    logic          last;

    // pick the lowest pending event
    always_comb begin
        sel = '0;
        for (int i = NC - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = SW'(i);
            end
        end
    end

    assign any  = |pend_reg;
    assign rest = pend_reg & ~(NC'(1) << sel);
    assign last = (rest == '0);
    assign emit = any && (!m_valid_reg || m_tready);
    assign idle = !any;

    // advance the pending mask and the output valid
    always_comb begin
        pend_next = pend_reg;
        if (ld.load) begin
            pend_next = cand_valid;
        end else if (emit) begin
            pend_next = rest;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the candidates and the output word
    always_ff @(posedge aclk) begin
        if (ld.load) begin
            code_reg  <= cand_code;
            press_reg <= cand_press;
            page_reg  <= ld.page;
        end
        if (emit) begin
            m_page_reg  <= page_reg;
            m_code_reg  <= code_reg[sel];
            m_press_reg <= press_reg[sel];
            m_last_reg  <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_press_reg, m_code_reg, m_page_reg};
    assign m_tlast  = m_last_reg;

    // a new report is only loaded once no event of the previous one is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        ld.load |-> (pend_reg == '0))
        else $error("report loaded while events still pending");

    // each sent word removes exactly one pending event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !ld.load) |=> ($countones(pend_reg) == $countones($past(pend_reg)) - 1))
        else $error("pending mask did not drop one event");

    // the word marked last leaves nothing pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last) |=> (pend_reg == '0) && m_tlast)
        else $error("last word sent with events still pending");

endmodule
